FILE: rtl/tpq_pkg.sv
// shared types and constants for the two-class priority queue with key dedup
// no dependencies; used by tpq_row and the top level
`default_nettype none
package tpq_pkg;

  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam int FUNC_W = 3;
  localparam int STAT_W = 3;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ_NORMAL = 3'd0,
    FUNC_ENQ_PREF   = 3'd1,
    FUNC_DEQUEUE    = 3'd2,
    FUNC_SEARCH     = 3'd3,
    FUNC_APP_NORMAL = 3'd4,
    FUNC_APP_PREF   = 3'd5
  } tpq_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } tpq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_RESP
  } tpq_state_e;

  // per-row control, one set per queue
  typedef struct packed {
    logic rotate;     // every cell takes its neighbor toward the head
    logic wr_en;      // write the tail cell
    logic scan_clr;   // start a new search
    logic scan_en;    // compare the head cell this cycle
    logic cmp_valid;  // head cell holds a live entry
  } tpq_row_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/tpq_cell.sv
// one queue cell: a key and payload register that can load from its neighbor
// or from the tail write port; no dependencies
`default_nettype none
module tpq_cell #(
  parameter int PBITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic [31:0]      nb_key_i,
  input  wire logic [PBITS-1:0] nb_pay_i,
  input  wire logic             wr_i,
  input  wire logic [31:0]      wr_key_i,
  input  wire logic [PBITS-1:0] wr_pay_i,
  output logic      [31:0]      key_o,
  output logic      [PBITS-1:0] pay_o
);

  logic [31:0]      key_q, key_d;
  logic [PBITS-1:0] pay_q, pay_d;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    priority if (wr_i) begin
      key_d = wr_key_i;
      pay_d = wr_pay_i;
    end else if (shift_i) begin
      key_d = nb_key_i;
      pay_d = nb_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule
`default_nettype wire

FILE: rtl/tpq_row.sv
// one queue: a ring of tpq_cell with the head at cell 0 and a head comparator
// depends on tpq_pkg and tpq_cell
`default_nettype none
module tpq_row #(
  parameter int DEPTH = tpq_pkg::DEF_QUEUE_DEPTH,
  parameter int PBITS = tpq_pkg::DEF_PAYLOAD_BITS,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tpq_pkg::tpq_row_ctrl_t ctrl_i,
  input  wire logic [IDX_W-1:0]       wr_idx_i,
  input  wire logic [31:0]            wr_key_i,
  input  wire logic [PBITS-1:0]       wr_pay_i,
  input  wire logic [31:0]            key_i,
  output logic      [31:0]            head_key_o,
  output logic      [PBITS-1:0]       head_pay_o,
  output logic                        found_o,
  output logic      [PBITS-1:0]       hit_pay_o
);

  logic [31:0]      key_w [DEPTH];
  logic [PBITS-1:0] pay_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % DEPTH;
    logic wr_sel;
    assign wr_sel = ctrl_i.wr_en && (wr_idx_i == IDX_W'(i));
    tpq_cell #(.PBITS(PBITS)) u_cell (
      .clk_i    (clk_i),
      .shift_i  (ctrl_i.rotate),
      .nb_key_i (key_w[NXT]),
      .nb_pay_i (pay_w[NXT]),
      .wr_i     (wr_sel),
      .wr_key_i (wr_key_i),
      .wr_pay_i (wr_pay_i),
      .key_o    (key_w[i]),
      .pay_o    (pay_w[i])
    );
  end

  assign head_key_o = key_w[0];
  assign head_pay_o = pay_w[0];

  // first live match while the ring turns is the oldest one
  logic found_q, found_d;
  logic hit_new;
  logic [PBITS-1:0] hit_q;

  assign hit_new = ctrl_i.scan_en && ctrl_i.cmp_valid && !found_q && (key_w[0] == key_i);

  always_comb begin
    found_d = found_q;
    priority if (ctrl_i.scan_clr) begin
      found_d = 1'b0;
    end else if (hit_new) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_clr) begin
      hit_q <= '0;
    end else if (hit_new) begin
      hit_q <= pay_w[0];
    end
  end

  assign found_o   = found_q;
  assign hit_pay_o = hit_q;

endmodule
`default_nettype wire

FILE: rtl/two_class_priority_queue_dedup_core.sv
// top level of the two-class strict-priority queue with key dedup
// depends on tpq_pkg, tpq_row and tpq_cell
`default_nettype none
// Two FIFOs (normal and preferential) of QUEUE_DEPTH entries, each entry a
// 32-bit key and a PAYLOAD_BITS payload, built as rings of cells with the
// head in cell 0. One request is handled at a time and gives exactly one
// response transaction. Checked enqueue and search rotate both rings once
// around, comparing the head cell against the key each cycle, then pass
// through a finish state before the response is offered. Dequeue, unchecked
// append and the unused codes act at accept and go straight to the response
// state. A new request is taken as soon as the previous one has moved to
// the output register, even while that response still waits for tready.
// Dequeue serves the preferential queue first. Stores are not cleared at
// reset; only the occupancy counts are.
module two_class_priority_queue_dedup_core #(
  parameter int QUEUE_DEPTH  = tpq_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = tpq_pkg::DEF_PAYLOAD_BITS,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_RAW_W  = tpq_pkg::KEY_W + 3 * tpq_pkg::PAY_W + 3 + 2 * CNT_W,
  localparam int OUT_TD_W   = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request channel
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] key, [95:32] payload
  input  wire logic [95:0]                s_axis_tdata,
  // [2:0] func
  input  wire logic [2:0]                 s_axis_tuser,
  // response channel
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // from bit 0 up: out_key 32, out_payload 64, out_from_pref 1, found_normal 1,
  // found_pref 1, normal_match_payload 64, pref_match_payload 64,
  // normal_count CNT_W, pref_count CNT_W, zero fill to whole bytes
  output logic [OUT_TD_W-1:0]             m_axis_tdata,
  // [2:0] status
  output logic [2:0]                      m_axis_tuser
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  // request fields
  logic                    in_acc;
  logic [2:0]              in_func;
  logic [31:0]             in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_func = s_axis_tuser;
  assign in_key  = s_axis_tdata[31:0];
  assign in_pay  = s_axis_tdata[32 +: PAYLOAD_BITS];

  // latched request
  logic [2:0]              func_q;
  logic [31:0]             key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_func;
      key_q  <= in_key;
      pay_q  <= in_pay;
    end
  end

  // control state
  tpq_pkg::tpq_state_e state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    nocc_q, nocc_d, pocc_q, pocc_d;

  // pending response
  tpq_pkg::tpq_status_e    res_stat_q, res_stat_d;
  logic [31:0]             res_key_q, res_key_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
  logic                    res_pref_q, res_pref_d;
  logic                    res_fn_q, res_fn_d;
  logic                    res_fp_q, res_fp_d;
  logic [PAYLOAD_BITS-1:0] res_nhit_q, res_nhit_d;
  logic [PAYLOAD_BITS-1:0] res_phit_q, res_phit_d;

  // row interface
  tpq_pkg::tpq_row_ctrl_t  n_ctrl, p_ctrl;
  logic [IDX_W-1:0]        n_wr_idx, p_wr_idx;
  logic [31:0]             wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;
  logic [31:0]             n_head_key, p_head_key;
  logic [PAYLOAD_BITS-1:0] n_head_pay, p_head_pay;
  logic                    n_found, p_found;
  logic [PAYLOAD_BITS-1:0] n_hit, p_hit;

  logic out_load;
  logic out_valid_q;

  // appends write from the port, checked enqueues from the latched request
  assign wr_key   = (state_q == tpq_pkg::ST_IDLE) ? in_key : key_q;
  assign wr_pay   = (state_q == tpq_pkg::ST_IDLE) ? in_pay : pay_q;
  assign n_wr_idx = nocc_q[IDX_W-1:0];
  assign p_wr_idx = pocc_q[IDX_W-1:0];

  assign s_axis_tready = (state_q == tpq_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    nocc_d     = nocc_q;
    pocc_d     = pocc_q;
    res_stat_d = res_stat_q;
    res_key_d  = res_key_q;
    res_pay_d  = res_pay_q;
    res_pref_d = res_pref_q;
    res_fn_d   = res_fn_q;
    res_fp_d   = res_fp_q;
    res_nhit_d = res_nhit_q;
    res_phit_d = res_phit_q;
    n_ctrl     = '0;
    p_ctrl     = '0;
    out_load   = 1'b0;

    unique case (state_q)
      tpq_pkg::ST_IDLE: begin
        if (in_acc) begin
          // fields that do not apply to the request read as zero
          res_stat_d = tpq_pkg::STAT_OK;
          res_key_d  = '0;
          res_pay_d  = '0;
          res_pref_d = 1'b0;
          res_fn_d   = 1'b0;
          res_fp_d   = 1'b0;
          res_nhit_d = '0;
          res_phit_d = '0;
          state_d    = tpq_pkg::ST_RESP;
          unique case (in_func)
            tpq_pkg::FUNC_ENQ_NORMAL, tpq_pkg::FUNC_ENQ_PREF, tpq_pkg::FUNC_SEARCH: begin
              n_ctrl.scan_clr = 1'b1;
              p_ctrl.scan_clr = 1'b1;
              idx_d           = '0;
              state_d         = tpq_pkg::ST_SCAN;
            end
            tpq_pkg::FUNC_DEQUEUE: begin
              // pop rotates the ring by one cell; the old head lands beyond the tail
              priority if (pocc_q != '0) begin
                res_key_d     = p_head_key;
                res_pay_d     = p_head_pay;
                res_pref_d    = 1'b1;
                p_ctrl.rotate = 1'b1;
                pocc_d        = pocc_q - CNT_W'(1);
              end else if (nocc_q != '0) begin
                res_key_d     = n_head_key;
                res_pay_d     = n_head_pay;
                n_ctrl.rotate = 1'b1;
                nocc_d        = nocc_q - CNT_W'(1);
              end else begin
                res_stat_d = tpq_pkg::STAT_EMPTY;
              end
            end
            tpq_pkg::FUNC_APP_NORMAL: begin
              if (nocc_q == FULL_CNT) begin
                res_stat_d = tpq_pkg::STAT_FULL;
              end else begin
                n_ctrl.wr_en = 1'b1;
                nocc_d       = nocc_q + CNT_W'(1);
              end
            end
            tpq_pkg::FUNC_APP_PREF: begin
              if (pocc_q == FULL_CNT) begin
                res_stat_d = tpq_pkg::STAT_FULL;
              end else begin
                p_ctrl.wr_en = 1'b1;
                pocc_d       = pocc_q + CNT_W'(1);
              end
            end
            default: begin
              // unused codes: no operation
            end
          endcase
        end
      end

      tpq_pkg::ST_SCAN: begin
        // one full turn of both rings, comparing the head cell each cycle
        n_ctrl.rotate    = 1'b1;
        p_ctrl.rotate    = 1'b1;
        n_ctrl.scan_en   = 1'b1;
        p_ctrl.scan_en   = 1'b1;
        n_ctrl.cmp_valid = CNT_W'(idx_q) < nocc_q;
        p_ctrl.cmp_valid = CNT_W'(idx_q) < pocc_q;
        idx_d            = idx_q + IDX_W'(1);
        if (idx_q == LAST_IDX) begin
          state_d = tpq_pkg::ST_FINISH;
        end
      end

      tpq_pkg::ST_FINISH: begin
        state_d = tpq_pkg::ST_RESP;
        if (func_q == tpq_pkg::FUNC_SEARCH) begin
          res_fn_d   = n_found;
          res_fp_d   = p_found;
          res_nhit_d = n_hit;
          res_phit_d = p_hit;
          if (!n_found && !p_found) begin
            res_stat_d = tpq_pkg::STAT_NOTFOUND;
          end
        end else begin
          // duplicate wins over full
          priority if (n_found || p_found) begin
            res_stat_d = tpq_pkg::STAT_DUP;
          end else if (func_q == tpq_pkg::FUNC_ENQ_PREF) begin
            if (pocc_q == FULL_CNT) begin
              res_stat_d = tpq_pkg::STAT_FULL;
            end else begin
              p_ctrl.wr_en = 1'b1;
              pocc_d       = pocc_q + CNT_W'(1);
            end
          end else begin
            if (nocc_q == FULL_CNT) begin
              res_stat_d = tpq_pkg::STAT_FULL;
            end else begin
              n_ctrl.wr_en = 1'b1;
              nocc_d       = nocc_q + CNT_W'(1);
            end
          end
        end
      end

      tpq_pkg::ST_RESP: begin
        // hand the response to the output register once it is free
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = tpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpq_pkg::ST_IDLE;
      idx_q   <= '0;
      nocc_q  <= '0;
      pocc_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      nocc_q  <= nocc_d;
      pocc_q  <= pocc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_stat_q <= res_stat_d;
    res_key_q  <= res_key_d;
    res_pay_q  <= res_pay_d;
    res_pref_q <= res_pref_d;
    res_fn_q   <= res_fn_d;
    res_fp_q   <= res_fp_d;
    res_nhit_q <= res_nhit_d;
    res_phit_q <= res_phit_d;
  end

  // queue rings
  tpq_row #(
    .DEPTH (QUEUE_DEPTH),
    .PBITS (PAYLOAD_BITS),
    .IDX_W (IDX_W)
  ) u_normal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (n_ctrl),
    .wr_idx_i   (n_wr_idx),
    .wr_key_i   (wr_key),
    .wr_pay_i   (wr_pay),
    .key_i      (key_q),
    .head_key_o (n_head_key),
    .head_pay_o (n_head_pay),
    .found_o    (n_found),
    .hit_pay_o  (n_hit)
  );

  tpq_row #(
    .DEPTH (QUEUE_DEPTH),
    .PBITS (PAYLOAD_BITS),
    .IDX_W (IDX_W)
  ) u_pref (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (p_ctrl),
    .wr_idx_i   (p_wr_idx),
    .wr_key_i   (wr_key),
    .wr_pay_i   (wr_pay),
    .key_i      (key_q),
    .head_key_o (p_head_key),
    .head_pay_o (p_head_pay),
    .found_o    (p_found),
    .hit_pay_o  (p_hit)
  );

  // output register, counts taken after the request has been applied
  logic [OUT_TD_W-1:0] out_td;
  logic [OUT_TD_W-1:0] out_tdata_q;
  logic [2:0]          out_tuser_q;

  always_comb begin
    out_td = '0;
    out_td[OUT_RAW_W-1:0] = {pocc_q, nocc_q,
                             tpq_pkg::PAY_W'(res_phit_q), tpq_pkg::PAY_W'(res_nhit_q),
                             res_fp_q, res_fn_q, res_pref_q,
                             tpq_pkg::PAY_W'(res_pay_q), res_key_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tdata_q <= out_td;
      out_tuser_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

endmodule
`default_nettype wire

FILE: tb/two_class_priority_queue_dedup_core_test.sv
// self-checking testbench for the two-class priority queue with key dedup
// needs tpq_pkg and the core rtl; a scoreboard class predicts every response,
// plain tasks drive the request stream and an initial block paces the response stream
module two_class_priority_queue_dedup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpq_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int CNT_W        = $clog2(DEF_QUEUE_DEPTH + 1);
  localparam int RESP_RAW_W   = KEY_W + 3 * PAY_W + 3 + 2 * CNT_W;
  localparam int RESP_W       = ((RESP_RAW_W + 7) / 8) * 8;
  localparam int FILL_W       = RESP_W - RESP_RAW_W;
  // longer than a full scan of the rings, so this leaves plenty of margin
  localparam int TAIL_CYCLES  = 2 * DEF_QUEUE_DEPTH + 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 56;
  localparam int PHASE_COUNT  = 8;

  // func codes with no operation behind them
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
  localparam logic [PAY_W-1:0]  PAYLOAD_MASK = {PAY_W{1'b1}} >> (PAY_W - DEF_PAYLOAD_BITS);

  typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} phase_e;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  out_key;
    logic [PAY_W-1:0]  out_payload;
    logic              from_pref;
    logic              found_normal;
    logic              found_pref;
    logic [PAY_W-1:0]  normal_match;
    logic [PAY_W-1:0]  pref_match;
    logic [CNT_W-1:0]  normal_count;
    logic [CNT_W-1:0]  pref_count;
    logic [FILL_W-1:0] fill;
  } response_t;

  // mirror of both queues plus the responses still owed by the core
  class dedup_queue_scoreboard;
    entry_t    normal_entries[$];
    entry_t    pref_entries[$];
    response_t expected_responses[$];
    int        mismatches;
    int        checked;
    int        op_seen[8];
    int        status_seen[8];

    // oldest entry with this key in one queue
    function bit lookup(bit in_pref, logic [KEY_W-1:0] key, output logic [PAY_W-1:0] hit);
      entry_t q[$];
      if (in_pref) q = pref_entries;
      else q = normal_entries;
      hit = '0;
      foreach (q[i]) begin
        if (q[i].key == key) begin
          hit = q[i].payload;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function logic [STAT_W-1:0] push(bit to_pref, logic [KEY_W-1:0] key,
                                     logic [PAY_W-1:0] payload);
      entry_t e;
      e.key     = key;
      e.payload = payload & PAYLOAD_MASK;
      if (to_pref) begin
        if (pref_entries.size() >= DEF_QUEUE_DEPTH) return STAT_FULL;
        pref_entries.push_back(e);
      end else begin
        if (normal_entries.size() >= DEF_QUEUE_DEPTH) return STAT_FULL;
        normal_entries.push_back(e);
      end
      return STAT_OK;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] payload);
      response_t r;
      entry_t    head;
      logic [PAY_W-1:0] hit_n, hit_p;
      bit        in_n, in_p;
      r = '{default: '0};
      r.status = STAT_OK;
      op_seen[func]++;
      case (func)
        FUNC_ENQ_NORMAL, FUNC_ENQ_PREF: begin
          // the duplicate check wins over a full target queue
          in_n = lookup(1'b0, key, hit_n);
          in_p = lookup(1'b1, key, hit_p);
          if (in_n || in_p) r.status = STAT_DUP;
          else r.status = push(func == FUNC_ENQ_PREF, key, payload);
        end
        FUNC_DEQUEUE: begin
          if (pref_entries.size() > 0) begin
            head = pref_entries.pop_front();
            r.out_key     = head.key;
            r.out_payload = head.payload;
            r.from_pref   = 1'b1;
          end else if (normal_entries.size() > 0) begin
            head = normal_entries.pop_front();
            r.out_key     = head.key;
            r.out_payload = head.payload;
          end else begin
            r.status = STAT_EMPTY;
          end
        end
        FUNC_SEARCH: begin
          r.found_normal = lookup(1'b0, key, hit_n);
          r.found_pref   = lookup(1'b1, key, hit_p);
          r.normal_match = hit_n;
          r.pref_match   = hit_p;
          if (!r.found_normal && !r.found_pref) r.status = STAT_NOTFOUND;
        end
        FUNC_APP_NORMAL: r.status = push(1'b0, key, payload);
        FUNC_APP_PREF:   r.status = push(1'b1, key, payload);
        default: ;
      endcase
      r.normal_count = CNT_W'(normal_entries.size());
      r.pref_count   = CNT_W'(pref_entries.size());
      status_seen[r.status]++;
      expected_responses.push_back(r);
    endfunction

    function void compare_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch on response %0d, %s: expected %h, got %h",
                   checked, name, want, got);
      end
    endfunction

    function void check_response(logic [STAT_W-1:0] user, logic [RESP_W-1:0] data);
      response_t want, got;
      checked++;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("response %0d arrived with nothing expected: status %0d data %h",
                   checked, user, data);
        return;
      end
      want = expected_responses.pop_front();
      got.status       = user;
      got.out_key      = data[0 +: KEY_W];
      got.out_payload  = data[KEY_W +: PAY_W];
      got.from_pref    = data[KEY_W + PAY_W];
      got.found_normal = data[KEY_W + PAY_W + 1];
      got.found_pref   = data[KEY_W + PAY_W + 2];
      got.normal_match = data[KEY_W + PAY_W + 3 +: PAY_W];
      got.pref_match   = data[KEY_W + 2 * PAY_W + 3 +: PAY_W];
      got.normal_count = data[KEY_W + 3 * PAY_W + 3 +: CNT_W];
      got.pref_count   = data[KEY_W + 3 * PAY_W + 3 + CNT_W +: CNT_W];
      got.fill         = data[RESP_RAW_W +: FILL_W];
      compare_field("status", PAY_W'(want.status), PAY_W'(got.status));
      compare_field("out_key", PAY_W'(want.out_key), PAY_W'(got.out_key));
      compare_field("out_payload", want.out_payload, got.out_payload);
      compare_field("out_from_pref", PAY_W'(want.from_pref), PAY_W'(got.from_pref));
      compare_field("found_normal", PAY_W'(want.found_normal), PAY_W'(got.found_normal));
      compare_field("found_pref", PAY_W'(want.found_pref), PAY_W'(got.found_pref));
      compare_field("normal_match_payload", want.normal_match, got.normal_match);
      compare_field("pref_match_payload", want.pref_match, got.pref_match);
      compare_field("normal_count", PAY_W'(want.normal_count), PAY_W'(got.normal_count));
      compare_field("pref_count", PAY_W'(want.pref_count), PAY_W'(got.pref_count));
      compare_field("zero fill", PAY_W'(want.fill), PAY_W'(got.fill));
    endfunction
  endclass

  // clock, reset and every core input start at known values
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata  = '0;   // [31:0] key, [95:32] payload
  logic [FUNC_W-1:0]   s_axis_tuser  = '0;   // [2:0] func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // from bit 0 up: out_key, out_payload, out_from_pref, found_normal, found_pref,
  // normal_match_payload, pref_match_payload, normal_count, pref_count, zero fill
  logic [RESP_W-1:0]   m_axis_tdata;
  logic [STAT_W-1:0]   m_axis_tuser;        // [2:0] status

  dedup_queue_scoreboard board;
  logic [KEY_W-1:0]      key_pool[8];
  bit                    sender_idles;
  int                    quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  two_class_priority_queue_dedup_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // one request transaction; a zero gap keeps tvalid high straight into the next one
  task automatic send_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                              logic [PAY_W-1:0] payload);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {payload, key};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(func, key, payload);
  endtask

  // hold the request side until the core has answered everything
  task automatic wait_for_responses();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.expected_responses.size() != 0);
  endtask

  // mostly keys of the current pool so duplicates and search hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_pool[$urandom_range(0, 7)];
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return {$urandom, $urandom};
    if (r < 92) return '0;
    return '1;
  endfunction

  // fill phases lean on one queue so it reaches full, drain phases empty both
  task automatic run_phase(phase_e kind, int n_items);
    int r;
    bit favor_pref, to_pref;
    logic [FUNC_W-1:0] func;
    favor_pref = $urandom_range(0, 1);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      to_pref = favor_pref ^ ($urandom_range(0, 4) == 0);
      case (kind)
        PHASE_FILL: begin
          if (r < 35)      func = to_pref ? FUNC_ENQ_PREF : FUNC_ENQ_NORMAL;
          else if (r < 75) func = to_pref ? FUNC_APP_PREF : FUNC_APP_NORMAL;
          else if (r < 87) func = FUNC_SEARCH;
          else if (r < 94) func = FUNC_DEQUEUE;
          else             func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
        end
        PHASE_DRAIN: begin
          if (r < 55)      func = FUNC_DEQUEUE;
          else if (r < 72) func = FUNC_SEARCH;
          else if (r < 84) func = to_pref ? FUNC_ENQ_PREF : FUNC_ENQ_NORMAL;
          else if (r < 95) func = to_pref ? FUNC_APP_PREF : FUNC_APP_NORMAL;
          else             func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
        end
        default: begin
          if (r < 22)      func = to_pref ? FUNC_ENQ_PREF : FUNC_ENQ_NORMAL;
          else if (r < 42) func = to_pref ? FUNC_APP_PREF : FUNC_APP_NORMAL;
          else if (r < 66) func = FUNC_DEQUEUE;
          else if (r < 92) func = FUNC_SEARCH;
          else             func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
        end
      endcase
      send_request(func, pick_key(), pick_payload());
    end
  endtask

  // response side: random stalls per transaction, with a stall-free stretch
  // every third block of 25 responses
  initial begin
    int stall;
    int served;
    served = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = ((served / 25) % 3 != 2) ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      served++;
    end
  end

  // every accepted response goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_response(m_axis_tuser, m_axis_tdata);
  end

  // watchdog: too long without any transaction on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("two_class_priority_queue_dedup_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int total;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idles = 1'b1;

    // directed: empty cases, field extremes, dedup across queues, spare codes
    send_request(FUNC_DEQUEUE, 32'h0, 64'h0);                       // both queues empty
    send_request(FUNC_SEARCH, 32'h0, 64'h0);                        // no match anywhere
    send_request(FUNC_ENQ_NORMAL, 32'h0, 64'h0);
    send_request(FUNC_ENQ_PREF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FUNC_ENQ_NORMAL, 32'hFFFF_FFFF, 64'h1);            // dup found in pref
    send_request(FUNC_ENQ_PREF, 32'h0, 64'h2);                      // dup found in normal
    send_request(FUNC_APP_PREF, 32'h0, 64'hA5A5_A5A5_A5A5_A5A5);    // unchecked dup is stored
    send_request(FUNC_APP_NORMAL, 32'h0, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(FUNC_SEARCH, 32'h0, 64'h0);                        // hit in both, oldest wins
    send_request(FUNC_SEARCH, 32'hFFFF_FFFF, 64'h3);                // pref only
    send_request(FUNC_SEARCH, 32'h1234_5678, 64'h0);
    send_request(FUNC_SPARE_6, 32'hDEAD_BEEF, 64'hFFFF_0000_FFFF_0000);
    send_request(FUNC_SPARE_7, 32'h0, 64'h0);
    send_request(FUNC_ENQ_NORMAL, 32'h8000_0000, 64'h8000_0000_0000_0001);
    // pref is served first, then normal in arrival order, then empty again
    repeat (6) send_request(FUNC_DEQUEUE, 32'h0, 64'h0);
    wait_for_responses();

    // random phases; every third phase runs back to back so queues hit full with dups waiting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      sender_idles = (p % 3 != 1);
      case (p % 4)
        0, 1:    run_phase(PHASE_FILL, PHASE_ITEMS);
        2:       run_phase(PHASE_MIX, PHASE_ITEMS);
        default: run_phase(PHASE_DRAIN, PHASE_ITEMS);
      endcase
      if (p % 2 == 1) wait_for_responses();
    end

    wait_for_responses();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    total = 0;
    foreach (board.op_seen[i]) total += board.op_seen[i];
    $display({"covered %0d requests: %0d checked enqueues, %0d appends, ",
              "%0d dequeues, %0d searches, %0d spare codes"},
             total, board.op_seen[FUNC_ENQ_NORMAL] + board.op_seen[FUNC_ENQ_PREF],
             board.op_seen[FUNC_APP_NORMAL] + board.op_seen[FUNC_APP_PREF],
             board.op_seen[FUNC_DEQUEUE], board.op_seen[FUNC_SEARCH],
             board.op_seen[FUNC_SPARE_6] + board.op_seen[FUNC_SPARE_7]);
    $display("statuses: %0d ok, %0d dup, %0d full, %0d empty, %0d not found; %0d mismatches",
             board.status_seen[STAT_OK], board.status_seen[STAT_DUP],
             board.status_seen[STAT_FULL], board.status_seen[STAT_EMPTY],
             board.status_seen[STAT_NOTFOUND], board.mismatches);
    if (board.mismatches == 0 && board.expected_responses.size() == 0) begin
      $display("two_class_priority_queue_dedup_core regression: pass");
    end else begin
      $display("two_class_priority_queue_dedup_core regression: fail");
    end
    $finish;
  end

endmodule
